>>> rtl/core/sqltl_pkg.sv
package sqltl_pkg;

  localparam int unsigned MaxQueryBytes = 65536;
  localparam int unsigned PosW = $clog2(MaxQueryBytes + 1);
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW = $clog2(MaxRes + 1);

  typedef enum logic [5:0] {
    TK_EOF = 6'd0, TK_UNKNOWN = 6'd1, TK_KW_BASE = 6'd2, TK_TRUE = 6'd23,
    TK_FALSE = 6'd24, TK_IDENT = 6'd25, TK_STRING = 6'd26, TK_INT32 = 6'd27,
    TK_INT64 = 6'd28, TK_DOUBLE = 6'd29, TK_EQ = 6'd30, TK_STAR = 6'd31,
    TK_LT = 6'd32, TK_LE = 6'd33, TK_NE = 6'd34, TK_GT = 6'd35, TK_GE = 6'd36,
    TK_SEMI = 6'd37, TK_LPAREN = 6'd38, TK_RPAREN = 6'd39, TK_COMMA = 6'd40,
    TK_DOT = 6'd41
  } tok_e;

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_INT, M_DOT, M_FRAC, M_STR, M_HELD, M_COMMENT
  } mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_query;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]         token_type;
    logic [15:0]        start_offset;
    logic [15:0]        token_length;
    logic signed [63:0] int_value;
    logic               last_result;
  } out_beat_t;

  typedef struct packed {
    logic [5:0]  ty;
    logic [31:0] st;
    logic [31:0] en;
    logic [63:0] val;
  } tok_t;

  function automatic logic [47:0] kw_word(input int unsigned i);
    case (i)
      0: kw_word = 48'h53454C454354; 1: kw_word = 48'h46524F4D;
      2: kw_word = 48'h5748455245;   3: kw_word = 48'h4A4F494E;
      4: kw_word = 48'h4F4E;         5: kw_word = 48'h4F52444552;
      6: kw_word = 48'h4259;         7: kw_word = 48'h494E53455254;
      8: kw_word = 48'h494E544F;     9: kw_word = 48'h555044415445;
      10: kw_word = 48'h435245415445; 11: kw_word = 48'h5441424C45;
      12: kw_word = 48'h534554;      13: kw_word = 48'h44454C455445;
      14: kw_word = 48'h56414C554553; 15: kw_word = 48'h414E44;
      16: kw_word = 48'h4F52;        17: kw_word = 48'h494E54;
      18: kw_word = 48'h43484152;    19: kw_word = 48'h424F4F4C;
      20: kw_word = 48'h4E554C4C;    21: kw_word = 48'h54525545;
      22: kw_word = 48'h46414C5345;  default: kw_word = '0;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input int unsigned i);
    case (i)
      0, 7, 9, 10, 13, 14: kw_len = 3'd6;
      2, 5, 11, 22: kw_len = 3'd5;
      1, 3, 8, 18, 19, 20, 21: kw_len = 3'd4;
      12, 15, 17: kw_len = 3'd3;
      default: kw_len = 3'd2;
    endcase
  endfunction

  function automatic tok_t mk(input logic [5:0] ty, input logic [31:0] st,
                              input logic [31:0] en, input logic [63:0] val);
    tok_t t;
    t.ty = ty; t.st = st; t.en = en; t.val = val;
    return t;
  endfunction

  function automatic out_beat_t to_beat(input tok_t t, input logic last);
    out_beat_t b;
    logic [31:0] len;
    len = (t.en > t.st) ? t.en - t.st : 32'd0;
    b.token_type = t.ty;
    b.start_offset = (t.st > 32'hFFFF) ? 16'hFFFF : t.st[15:0];
    b.token_length = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
    b.int_value = t.val;
    b.last_result = last;
    return b;
  endfunction

endpackage

>>> rtl/core/sql_token_lexer_top.sv
// channel | dir | payload    | handshake
// in      | in  | in_beat_t  | in_valid_i / in_stall_o
// out     | out | out_beat_t | out_valid_o / out_stall_i
// One input beat per cycle while in_stall_o is low; the beat is registered, then lexed combinationally.
// Each lexed beat pushes up to four tokens into an 8-entry output queue.
// The first token of a beat is offered once the beat has passed the input register and been written into the queue.
// Stall the input while the queue level plus the registered beat's tokens exceeds four.
// Reset returns the lexer to idle at offset zero and empties the queue.
module sql_token_lexer_top import sqltl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic         iv_q;
  in_beat_t     ib_q;
  tok_t [3:0]   tk;
  logic [CntW-1:0] cnt;
  out_beat_t    fifo_q [8];
  logic [2:0]   rd_q, wr_q;
  logic [3:0]   lvl_q, lvl_d;
  logic         pop, adv;

  assign pop = out_valid_o && !out_stall_i;
  assign in_stall_o = (lvl_q + (iv_q ? {1'b0, cnt} : 4'd0)) > 4'd4;
  assign adv = iv_q;

  sqltl_lex u_lex (
    .clk_i, .rst_ni, .adv_i(adv), .beat_i(ib_q), .tok_o(tk), .cnt_o(cnt)
  );

  always_comb begin
    lvl_d = lvl_q + (adv ? {1'b0, cnt} : 4'd0) - {3'd0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0; rd_q <= '0; wr_q <= '0; lvl_q <= '0;
    end else begin
      iv_q <= in_valid_i && !in_stall_o;
      if (pop) rd_q <= rd_q + 3'd1;
      if (adv) wr_q <= wr_q + 3'(cnt);
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) ib_q <= in_data_i;
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < cnt) fifo_q[3'(wr_q + 3'(i))] <= to_beat(tk[2'(i)], 3'(i + 1) == cnt);
      end
    end
  end

  assign out_valid_o = lvl_q != 4'd0;
  assign out_data_o = fifo_q[rd_q];

  a_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni) lvl_q <= 4'd8)
    else $error("queue overflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni) iv_q |-> cnt <= 3'd4)
    else $error("too many tokens");
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iv_q |-> lvl_q + {1'b0, cnt} <= 4'd8) else $error("no room for beat");

endmodule

>>> rtl/core/sqltl_lex.sv
module sqltl_lex import sqltl_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  in_beat_t       beat_i,
  output tok_t [3:0]     tok_o,
  output logic [CntW-1:0] cnt_o
);

  mode_e        mode_q, mode_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [31:0]  tst_q, tst_d;
  logic [47:0]  wp_q, wp_d;
  logic [15:0]  wl_q, wl_d;
  logic [1:0]   cf_q, cf_d;
  logic [63:0]  acc_q, acc_d;
  logic [2:0]   nf_q, nf_d;
  logic [7:0]   ho_q, ho_d;

  tok_t [3:0]   t;
  logic [CntW-1:0] n;
  logic [31:0]  p;
  logic [7:0]   c;
  logic         feed, isl, isd, ws;
  logic [3:0]   dg;
  tok_t         wtok, itok, hs;
  logic [63:0]  acc_x10, acc_nx;
  logic         ovf_nx;
  logic [31:0]  fend;

  function automatic logic is_letter(input logic [7:0] x);
    logic [7:0] l;
    l = x | 8'h20;
    return !x[7] && l >= 8'h61 && l <= 8'h7A;
  endfunction

  always_comb begin
    logic [63:0] lim;
    lim = nf_q[0] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    acc_x10 = (acc_q << 3) + (acc_q << 1);
    acc_nx = acc_x10 + {60'd0, dg};
    ovf_nx = (acc_q > 64'h1999999999999999) || (acc_x10 > lim) || (acc_nx > lim);
  end

  always_comb begin
    wtok = mk(TK_IDENT, tst_q, p, '0);
    if (wl_q <= 16'd6 && cf_q != 2'd0) begin
      for (int unsigned i = 0; i < 23; i++) begin
        if (wtok.ty == TK_IDENT && {13'd0, kw_len(i)} == wl_q && kw_word(i) == wp_q) begin
          wtok.ty = TK_KW_BASE + 6'(i);
          wtok.val = (6'(TK_KW_BASE + 6'(i)) == TK_TRUE) ? 64'd1 : 64'd0;
        end
      end
    end
  end

  function automatic tok_t int_tok(input logic [31:0] st, input logic [31:0] en,
                                   input logic [63:0] a, input logic [2:0] f);
    logic sm;
    if (f[1]) return mk(TK_UNKNOWN, st, en, '0);
    sm = f[0] ? (a <= 64'h80000000) : (a <= 64'h7FFFFFFF);
    return mk(sm ? TK_INT32 : TK_INT64, st, en, f[0] ? 64'd0 - a : a);
  endfunction

  always_comb begin
    logic [31:0] fe;
    tok_t w;
    c = beat_i.ch;
    p = {{(32-PosW){1'b0}}, pos_q};
    feed = beat_i.has_char && (p < MaxQueryBytes);
    isl = is_letter(c);
    isd = c >= 8'h30 && c <= 8'h39;
    dg = c[3:0];
    ws = c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    hs = mk((ho_q == 8'h3C) ? TK_LT : (ho_q == 8'h3E) ? TK_GT : TK_UNKNOWN,
            tst_q, tst_q + 32'd1, '0);
    itok = int_tok(tst_q, p, acc_q, nf_q);
    mode_d = mode_q; pos_d = pos_q; tst_d = tst_q; wp_d = wp_q; wl_d = wl_q;
    cf_d = cf_q; acc_d = acc_q; nf_d = nf_q; ho_d = ho_q;
    t = '0; n = '0;
    fend = p;
    fe = p;
    w = '0;
    if (feed) begin
      logic fr;
      fr = 1'b0;
      fend = p + 32'd1;
      pos_d = pos_q + 1'b1;
      unique case (mode_q)
        M_WORD: begin
          if (isl || c == 8'h5F) begin
            if (wl_q < 16'd6) wp_d = {wp_q[39:0], (c == 8'h5F) ? c : (c & 8'hDF)};
            if (wl_q < 16'hFFFF) wl_d = wl_q + 16'd1;
            if (c == 8'h5F) cf_d = 2'd0;
            else if (c >= 8'h61) cf_d = cf_q & 2'd2;
            else cf_d = cf_q & 2'd1;
          end else begin
            t[n[1:0]] = wtok; n = n + 1'b1; fr = 1'b1;
          end
        end
        M_INT: begin
          if (isd) begin
            if (!nf_q[1]) begin
              if (ovf_nx) nf_d[1] = 1'b1;
              else acc_d = acc_nx;
            end
          end else if (c == 8'h2E) mode_d = M_DOT;
          else begin
            t[n[1:0]] = itok; n = n + 1'b1; fr = 1'b1;
          end
        end
        M_DOT: begin
          if (isd) begin
            mode_d = M_FRAC; nf_d[2] = 1'b1;
          end else begin
            t[n[1:0]] = int_tok(tst_q, p - 32'd1, acc_q, nf_q); n = n + 1'b1;
            t[n[1:0]] = mk(TK_DOT, p - 32'd1, p, '0); n = n + 1'b1; fr = 1'b1;
          end
        end
        M_FRAC: begin
          if (!isd) begin
            t[n[1:0]] = mk(TK_DOUBLE, tst_q, p, '0); n = n + 1'b1; fr = 1'b1;
          end
        end
        M_STR: begin
          if (c == 8'h27) begin
            t[n[1:0]] = mk(TK_STRING, tst_q, p + 32'd1, '0); n = n + 1'b1;
            mode_d = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (c == 8'h0A) mode_d = M_IDLE;
        end
        M_HELD: begin
          mode_d = M_IDLE;
          if (ho_q == 8'h3C && (c == 8'h3D || c == 8'h3E)) begin
            t[n[1:0]] = mk((c == 8'h3D) ? TK_LE : TK_NE, tst_q, p + 32'd1, '0);
            n = n + 1'b1;
          end else if ((ho_q == 8'h3E || ho_q == 8'h21) && c == 8'h3D) begin
            t[n[1:0]] = mk((ho_q == 8'h3E) ? TK_GE : TK_NE, tst_q, p + 32'd1, '0);
            n = n + 1'b1;
          end else if (ho_q == 8'h2F && c == 8'h2F) mode_d = M_COMMENT;
          else if (ho_q == 8'h2D && isd) begin
            mode_d = M_INT; nf_d = 3'b001; acc_d = {60'd0, dg};
          end else begin
            t[n[1:0]] = hs; n = n + 1'b1; fr = 1'b1;
          end
        end
        default: fr = 1'b1;
      endcase
      if (fr) begin
        mode_d = M_IDLE;
        if (c[7]) begin
          t[n[1:0]] = mk(TK_UNKNOWN, p, p + 32'd1, '0); n = n + 1'b1;
        end else if (!ws) begin
          tst_d = p;
          if (isl || c == 8'h5F) begin
            mode_d = M_WORD; wl_d = 16'd1;
            wp_d = {40'd0, (c == 8'h5F) ? c : (c & 8'hDF)};
            cf_d = (c == 8'h5F) ? 2'd0 : (c >= 8'h61) ? 2'd2 : 2'd1;
          end else if (isd) begin
            mode_d = M_INT; nf_d = '0; acc_d = {60'd0, dg};
          end else begin
            case (c) inside
              8'h27: mode_d = M_STR;
              8'h3C, 8'h3E, 8'h21, 8'h2F, 8'h2D: begin
                mode_d = M_HELD; ho_d = c;
              end
              default: begin
                case (c)
                  8'h3D: t[n[1:0]] = mk(TK_EQ, p, p + 32'd1, '0);
                  8'h2A: t[n[1:0]] = mk(TK_STAR, p, p + 32'd1, '0);
                  8'h3B: t[n[1:0]] = mk(TK_SEMI, p, p + 32'd1, '0);
                  8'h28: t[n[1:0]] = mk(TK_LPAREN, p, p + 32'd1, '0);
                  8'h29: t[n[1:0]] = mk(TK_RPAREN, p, p + 32'd1, '0);
                  8'h2C: t[n[1:0]] = mk(TK_COMMA, p, p + 32'd1, '0);
                  8'h2E: t[n[1:0]] = mk(TK_DOT, p, p + 32'd1, '0);
                  default: t[n[1:0]] = mk(TK_UNKNOWN, p, p + 32'd1, '0);
                endcase
                n = n + 1'b1;
              end
            endcase
          end
        end
      end
    end
    if (beat_i.end_of_query) begin
      fe = fend;
      if (!feed) begin
        unique case (mode_q)
          M_WORD: begin
            t[n[1:0]] = mk(wtok.ty, tst_q, fe, wtok.val); n = n + 1'b1;
          end
          M_INT: begin t[n[1:0]] = int_tok(tst_q, fe, acc_q, nf_q); n = n + 1'b1; end
          M_DOT: begin
            t[n[1:0]] = int_tok(tst_q, fe - 32'd1, acc_q, nf_q); n = n + 1'b1;
            t[n[1:0]] = mk(TK_DOT, fe - 32'd1, fe, '0); n = n + 1'b1;
          end
          M_FRAC: begin t[n[1:0]] = mk(TK_DOUBLE, tst_q, fe, '0); n = n + 1'b1; end
          M_STR: begin t[n[1:0]] = mk(TK_UNKNOWN, tst_q, fe, '0); n = n + 1'b1; end
          M_HELD: begin t[n[1:0]] = hs; n = n + 1'b1; end
          default: ;
        endcase
      end else begin
        unique case (mode_d)
          M_WORD: begin
            w = mk(TK_IDENT, tst_d, fe, '0);
            if (wl_d <= 16'd6 && cf_d != 2'd0) begin
              for (int unsigned i = 0; i < 23; i++) begin
                if (w.ty == TK_IDENT && {13'd0, kw_len(i)} == wl_d
                    && kw_word(i) == wp_d) begin
                  w.ty = TK_KW_BASE + 6'(i);
                  w.val = (6'(TK_KW_BASE + 6'(i)) == TK_TRUE) ? 64'd1 : 64'd0;
                end
              end
            end
            t[n[1:0]] = w;
            n = n + 1'b1;
          end
          M_INT: begin t[n[1:0]] = int_tok(tst_d, fe, acc_d, nf_d); n = n + 1'b1; end
          M_DOT: begin
            t[n[1:0]] = int_tok(tst_d, fe - 32'd1, acc_d, nf_d); n = n + 1'b1;
            t[n[1:0]] = mk(TK_DOT, fe - 32'd1, fe, '0); n = n + 1'b1;
          end
          M_FRAC: begin t[n[1:0]] = mk(TK_DOUBLE, tst_d, fe, '0); n = n + 1'b1; end
          M_STR: begin t[n[1:0]] = mk(TK_UNKNOWN, tst_d, fe, '0); n = n + 1'b1; end
          M_HELD: begin
            t[n[1:0]] = mk((ho_d == 8'h3C) ? TK_LT : (ho_d == 8'h3E) ? TK_GT : TK_UNKNOWN,
                           tst_d, tst_d + 32'd1, '0);
            n = n + 1'b1;
          end
          default: ;
        endcase
      end
      t[n[1:0]] = mk(TK_EOF, fe, fe, '0); n = n + 1'b1;
      mode_d = M_IDLE; pos_d = '0; tst_d = '0; wp_d = '0; wl_d = '0;
      cf_d = 2'd3; acc_d = '0; nf_d = '0; ho_d = '0;
    end
  end

  assign tok_o = t;
  assign cnt_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pos_q <= '0; tst_q <= '0; wp_q <= '0; wl_q <= '0;
      cf_q <= 2'd3; acc_q <= '0; nf_q <= '0; ho_q <= '0;
    end else if (adv_i) begin
      mode_q <= mode_d; pos_q <= pos_d; tst_q <= tst_d; wp_q <= wp_d;
      wl_q <= wl_d; cf_q <= cf_d; acc_q <= acc_d; nf_q <= nf_d; ho_q <= ho_d;
    end
  end

endmodule
